>>> src/fbs_pkg.sv
// Shared types and constants for the flame bearing selector.
package fbs_pkg;

  // Input opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_EVAL  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PICK_LOWEST = 2'd1;

  localparam logic [9:0] TOLERANCE_RESET   = 10'd20;
  localparam logic       PICK_LOWEST_RESET = 1'b0;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] angle;
    logic [9:0] reading;
  } in_item_t;

  typedef struct packed {
    logic [7:0] best_angle;
    logic [9:0] min_level;
    logic       found;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_WRITE,
    CMD_EVAL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] angle;
    logic [9:0] reading;
  } cmd_t;

  // Head of the command queue, front to back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  // Back status, back to front
  typedef struct packed {
    logic init_busy;
    logic cmd_pop;
  } back_status_t;

endpackage

>>> src/fbs_front.sv
// Front end: accepts input items, classifies them and queues commands for the back end.
module fbs_front #(
  parameter int NUM_ANGLES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  fbs_pkg::in_item_t    in_item,
  input  fbs_pkg::back_status_t status,
  output fbs_pkg::head_t       head
);

  fbs_pkg::cmd_t                q [fbs_pkg::QDEPTH];
  logic [fbs_pkg::QPTR_W-1:0]   wr_ptr;
  logic [fbs_pkg::QPTR_W-1:0]   rd_ptr;
  logic [fbs_pkg::QPTR_W:0]     count;

  fbs_pkg::cmd_t cmd_in;
  logic          keep;
  logic          accept;
  logic          enq;
  logic          deq;

  // Classify: drop unused opcodes and writes beyond the store
  always_comb begin
    cmd_in.angle   = in_item.angle;
    cmd_in.reading = in_item.reading;
    cmd_in.kind    = fbs_pkg::CMD_CLEAR;
    keep           = 1'b0;
    case (in_item.opcode)
      fbs_pkg::OP_CLEAR: begin
        cmd_in.kind = fbs_pkg::CMD_CLEAR;
        keep        = 1'b1;
      end
      fbs_pkg::OP_WRITE: begin
        cmd_in.kind = fbs_pkg::CMD_WRITE;
        keep        = ({3'b000, in_item.angle} < 11'(NUM_ANGLES));
      end
      fbs_pkg::OP_EVAL: begin
        cmd_in.kind = fbs_pkg::CMD_EVAL;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full   = (count == (fbs_pkg::QPTR_W + 1)'(fbs_pkg::QDEPTH)) || status.init_busy;
  assign accept = push && !full;
  assign enq    = accept && keep;
  assign deq    = status.cmd_pop;

  assign head.valid = (count != '0);
  assign head.cmd   = q[rd_ptr];

  // Store queued commands
  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({enq, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/fbs_back.sv
// Back end: reading store, clear sweep, evaluate of up to two passes and result register.
module fbs_back #(
  parameter int NUM_ANGLES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fbs_pkg::head_t        head,
  output fbs_pkg::back_status_t status,
  input  logic [9:0]            tolerance,
  input  logic                  pick_lowest,
  input  logic                  pop,
  output logic                  empty,
  output fbs_pkg::out_item_t    out_item
);

  localparam int AW = $clog2(NUM_ANGLES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MIN,
    S_PICK,
    S_REPORT
  } state_t;

  state_t            state;
  logic [AW-1:0]     scan_addr;
  logic              issue_done;
  logic              rd_vld;
  logic              rd_last;
  logic [AW-1:0]     rd_idx;
  logic [9:0]        rd_data;
  logic [9:0]        min_val;
  logic              any_min;
  logic [AW-1:0]     best;
  logic              chosen;
  logic              init_busy;
  logic              out_valid;
  fbs_pkg::out_item_t out_q;

  logic [9:0]        mem [NUM_ANGLES];

  logic              cmd_take;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [9:0]        wr_data;
  logic              rd_en;
  logic              last_addr;
  logic              v_nz;
  logic [9:0]        diff;
  logic              qual;
  logic              out_free;
  logic [AW+7:0]     angle_wide;
  logic [AW+7:0]     best_wide;

  assign cmd_take   = (state == S_IDLE) && head.valid;
  assign angle_wide = {{AW{1'b0}}, head.cmd.angle};
  assign best_wide  = {8'b0, best};

  // Select the write port: clear sweep or a write command
  assign wr_en   = (state == S_CLEAR) || (cmd_take && (head.cmd.kind == fbs_pkg::CMD_WRITE));
  assign wr_addr = (state == S_CLEAR) ? scan_addr : angle_wide[AW-1:0];
  assign wr_data = (state == S_CLEAR) ? 10'd0 : head.cmd.reading;

  assign rd_en     = ((state == S_MIN) || (state == S_PICK)) && !issue_done;
  assign last_addr = (scan_addr == AW'(NUM_ANGLES - 1));

  // Qualify the reading that came back from the store
  assign v_nz = (rd_data != 10'd0);
  assign diff = rd_data - min_val;
  assign qual = v_nz && (diff < tolerance);

  assign out_free = !out_valid || pop;

  assign status.init_busy = init_busy;
  assign status.cmd_pop   = cmd_take;
  assign empty            = !out_valid;
  assign out_item         = out_q;

  // Store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[scan_addr];
      rd_idx  <= scan_addr;
    end
  end

  // Sequence clear, scan passes and report
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      scan_addr  <= '0;
      issue_done <= 1'b0;
      rd_vld     <= 1'b0;
      rd_last    <= 1'b0;
      any_min    <= 1'b0;
      chosen     <= 1'b0;
      init_busy  <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && pop) begin
        out_valid <= 1'b0;
      end
      rd_vld  <= rd_en;
      rd_last <= rd_en && last_addr;
      if (rd_en) begin
        scan_addr  <= last_addr ? '0 : scan_addr + 1'b1;
        issue_done <= last_addr;
      end
      case (state)
        S_CLEAR: begin
          scan_addr <= last_addr ? '0 : scan_addr + 1'b1;
          if (last_addr) begin
            state     <= S_IDLE;
            init_busy <= 1'b0;
          end
        end
        S_IDLE: begin
          if (head.valid) begin
            case (head.cmd.kind)
              fbs_pkg::CMD_CLEAR: begin
                state     <= S_CLEAR;
                scan_addr <= '0;
              end
              fbs_pkg::CMD_EVAL: begin
                state      <= S_MIN;
                scan_addr  <= '0;
                issue_done <= 1'b0;
                any_min    <= 1'b0;
                chosen     <= 1'b0;
                best       <= '0;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_MIN: begin
          if (rd_vld && v_nz) begin
            if (!any_min || (rd_data < min_val)) begin
              min_val <= rd_data;
            end
            any_min <= 1'b1;
          end
          if (rd_vld && rd_last) begin
            issue_done <= 1'b0;
            state      <= (any_min || v_nz) ? S_PICK : S_REPORT;
          end
        end
        S_PICK: begin
          if (rd_vld && qual) begin
            if (!(pick_lowest && chosen)) begin
              best <= rd_idx;
            end
            chosen <= 1'b1;
          end
          if (rd_vld && rd_last) begin
            state <= S_REPORT;
          end
        end
        S_REPORT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            out_q.best_angle <= best_wide[7:0];
            out_q.min_level  <= any_min ? min_val : 10'd0;
            out_q.found      <= any_min;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_empty_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_q.found) |-> (out_q.best_angle == 8'd0 && out_q.min_level == 10'd0))
    else $error("result without a reading carries nonzero fields");

  a_read_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == S_MIN || state == S_PICK))
    else $error("store read data outside a scan pass");

  a_pick_needs_min: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK) |-> any_min)
    else $error("pick pass without a minimum");

  a_init_in_clear: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> (state == S_CLEAR && !cmd_take))
    else $error("command taken during the clearing pass after reset");

endmodule

>>> src/flame_bearing_selector.sv
// Top level of the flame bearing selector: configuration registers, front and back ends.
//
//   channel   ports                                      transfer at rising edge when
//   input     push, full, in_item                        push && !full
//   result    pop, empty, out_item                       pop && !empty
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// A write is done when the back end takes it, a clear sweeps every address of the store,
// and an evaluate reads the store once for the minimum and, if a reading was nonzero,
// once more to pick, both passes going through the single read port of the reading store.
// After reset the store is cleared; full stays high meanwhile.
// A four-entry command queue lets input items pile up while the back end works; the
// back end holds a finished result in its output register until pop takes it.
module flame_bearing_selector #(
  parameter int NUM_ANGLES = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  fbs_pkg::in_item_t               in_item,
  input  logic                            pop,
  output logic                            empty,
  output fbs_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [9:0]            tolerance;
  logic                  pick_lowest;
  fbs_pkg::head_t        head;
  fbs_pkg::back_status_t status;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance   <= fbs_pkg::TOLERANCE_RESET;
      pick_lowest <= fbs_pkg::PICK_LOWEST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbs_pkg::CFG_TOLERANCE:   tolerance   <= cfg_data;
        fbs_pkg::CFG_PICK_LOWEST: pick_lowest <= cfg_data[0];
        default: begin
          tolerance <= tolerance;
        end
      endcase
    end
  end

  fbs_front #(
    .NUM_ANGLES(NUM_ANGLES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .status  (status),
    .head    (head)
  );

  fbs_back #(
    .NUM_ANGLES(NUM_ANGLES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .status      (status),
    .tolerance   (tolerance),
    .pick_lowest (pick_lowest),
    .pop         (pop),
    .empty       (empty),
    .out_item    (out_item)
  );

endmodule
